### design/tsm_pkg.sv
// shared types, constants and helpers for the token substring matcher
// no dependencies; used by every module of the block by scoped names
package tsm_pkg;

   localparam int MAX_KEY_LEN = 16;
   localparam int KEY_LEN_W   = $clog2(MAX_KEY_LEN + 1);
   localparam int KEY_IDX_W   = $clog2(MAX_KEY_LEN);

   localparam logic [7:0]  CHAR_SPACE    = 8'h20;
   localparam logic [7:0]  CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0]  CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0]  CHAR_UPPER_Z  = 8'h5A;
   localparam logic [7:0]  CASE_OFFSET   = 8'h20;
   localparam logic [7:0]  OFFSET_MAX    = 8'hFF;
   localparam logic [15:0] TOTAL_MAX     = 16'hFFFF;

   typedef enum logic [1:0] {
      CSR_KEY_LOW  = 2'd0,
      CSR_KEY_HIGH = 2'd1,
      CSR_KEY_LEN  = 2'd2,
      CSR_FOLD     = 2'd3
   } csr_index_type;

   typedef logic [MAX_KEY_LEN-1:0][7:0] key_bytes_type;

   typedef struct packed {
      key_bytes_type        key;
      logic [KEY_LEN_W-1:0] key_length;
      logic                 fold_case;
   } cfg_type;

   // per-item control from the input stage
   typedef struct packed {
      logic shift;   // plain byte joins the token
      logic close;   // token ends with this item
   } step_type;

   typedef struct packed {
      logic [15:0] match_total;
      logic [7:0]  first_offset;
      logic        token_matched;
   } result_type;

   function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
      logic [7:0] r;
      r = c;
      if (en && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_NEWLINE);
   endfunction

endpackage

### design/tsm_csr.sv
// configuration registers: keyword bytes, keyword length and case folding
// depends on tsm_pkg
module tsm_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [63:0]         csr_data,
   output tsm_pkg::cfg_type    cfg
);

   logic [63:0]                     key_low_ff,  key_low_in;
   logic [63:0]                     key_high_ff, key_high_in;
   logic [tsm_pkg::KEY_LEN_W-1:0]   key_len_ff,  key_len_in;
   logic                            fold_ff,     fold_in;
   tsm_pkg::csr_index_type          index;

   assign csr_ready = 1'b1;
   assign index     = tsm_pkg::csr_index_type'(csr_index);

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      key_len_in  = key_len_ff;
      fold_in     = fold_ff;
      if (csr_valid) begin
         unique case (index)
            tsm_pkg::CSR_KEY_LOW:  key_low_in  = csr_data;
            tsm_pkg::CSR_KEY_HIGH: key_high_in = csr_data;
            tsm_pkg::CSR_KEY_LEN:  key_len_in  = csr_data[tsm_pkg::KEY_LEN_W-1:0];
            tsm_pkg::CSR_FOLD:     fold_in     = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= '0;
         fold_ff     <= 1'b0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         key_len_ff  <= key_len_in;
         fold_ff     <= fold_in;
      end
   end

   assign cfg.key        = tsm_pkg::key_bytes_type'({key_high_ff, key_low_ff});
   assign cfg.key_length = key_len_ff;
   assign cfg.fold_case  = fold_ff;

endmodule

### design/tsm_window.sv
// sliding window of the newest token bytes and the parallel keyword compare
// depends on tsm_pkg
module tsm_window (
   input  logic               clock,
   input  logic               shift,
   input  logic [7:0]         text_byte,
   input  tsm_pkg::cfg_type   cfg,
   output logic               key_hit
);

   // newest byte at index 0
   logic [tsm_pkg::MAX_KEY_LEN-1:0][7:0] recent_ff, recent_in;
   logic [tsm_pkg::MAX_KEY_LEN-1:0]      lane_ok;
   logic                                 len_ok;

   always_comb begin
      recent_in[0] = text_byte;
      for (int j = 1; j < tsm_pkg::MAX_KEY_LEN; j++) begin
         recent_in[j] = recent_ff[j-1];
      end
   end

   // key byte i lines up with window byte (length - 1 - i)
   always_comb begin
      logic [tsm_pkg::KEY_LEN_W-1:0] sel;
      for (int i = 0; i < tsm_pkg::MAX_KEY_LEN; i++) begin
         sel = cfg.key_length - tsm_pkg::KEY_LEN_W'(1) - tsm_pkg::KEY_LEN_W'(i);
         lane_ok[i] = (tsm_pkg::KEY_LEN_W'(i) >= cfg.key_length) ||
            (tsm_pkg::fold_char(cfg.key[i], cfg.fold_case) ==
             tsm_pkg::fold_char(recent_in[sel[tsm_pkg::KEY_IDX_W-1:0]], cfg.fold_case));
      end
   end

   assign len_ok  = (cfg.key_length != '0) &&
                    (cfg.key_length <= tsm_pkg::KEY_LEN_W'(tsm_pkg::MAX_KEY_LEN));
   assign key_hit = len_ok && (&lane_ok);

   always_ff @(posedge clock) begin
      if (shift) begin
         recent_ff <= recent_in;
      end
   end

endmodule

### design/tsm_tracker.sv
// per-token position and first-hit tracking, match total and result register
// depends on tsm_pkg
module tsm_tracker (
   input  logic                           clock,
   input  logic                           reset,
   input  tsm_pkg::step_type              step,
   input  logic                           key_hit,
   input  logic [tsm_pkg::KEY_LEN_W-1:0]  key_length,
   input  logic                           rsp_tready,
   output logic                           rsp_valid,
   output tsm_pkg::result_type            result
);

   logic [7:0]          pos_ff,    pos_in;
   logic                seen_ff,   seen_in;
   logic [7:0]          offset_ff, offset_in;
   logic [15:0]         total_ff,  total_in;
   logic                valid_ff,  valid_in;
   tsm_pkg::result_type result_ff, result_in;

   logic [7:0]  pos_step;
   logic        sat;
   logic        hit_now;
   logic        seen_next;
   logic [7:0]  offset_next;
   logic        emit;

   always_comb begin
      sat       = (pos_ff == tsm_pkg::OFFSET_MAX);
      pos_step  = pos_ff;
      if (step.shift && !sat) begin
         pos_step = pos_ff + 8'd1;
      end
      hit_now     = step.shift && !seen_ff && key_hit &&
                    (pos_step >= 8'(key_length));
      seen_next   = seen_ff | hit_now;
      offset_next = offset_ff;
      if (hit_now) begin
         offset_next = sat ? tsm_pkg::OFFSET_MAX : (pos_step - 8'(key_length));
      end
      emit = step.close && (pos_step != 8'd0);

      total_in = total_ff;
      if (emit && seen_next && total_ff != tsm_pkg::TOTAL_MAX) begin
         total_in = total_ff + 16'd1;
      end

      if (step.close) begin
         pos_in    = '0;
         seen_in   = 1'b0;
         offset_in = '0;
      end else begin
         pos_in    = pos_step;
         seen_in   = seen_next;
         offset_in = offset_next;
      end

      result_in = result_ff;
      valid_in  = valid_ff && !rsp_tready;
      if (emit) begin
         valid_in                = 1'b1;
         result_in.token_matched = seen_next;
         result_in.first_offset  = seen_next ? offset_next : 8'd0;
         result_in.match_total   = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         seen_ff   <= 1'b0;
         offset_ff <= '0;
         total_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         seen_ff   <= seen_in;
         offset_ff <= offset_in;
         total_ff  <= total_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid = valid_ff;
   assign result    = result_ff;

   a_total_steps: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (total_ff == $past(total_ff)) || (total_ff == $past(total_ff) + 16'd1))
      else $error("match total moved by more than one");

   a_offset_needs_hit: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> (offset_ff == 8'd0))
      else $error("hit offset set without a hit");

   a_hit_needs_token: assert property (@(posedge clock) disable iff (reset)
      (pos_ff == 8'd0) |-> !seen_ff)
      else $error("hit recorded in an empty token");

   a_miss_zero_offset: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !result_ff.token_matched) |-> (result_ff.first_offset == 8'd0))
      else $error("non-matching result carries an offset");

endmodule

### design/token_substring_matcher.sv
// top level of the token substring matcher: input register, window, tracker
// depends on tsm_pkg, tsm_csr, tsm_window, tsm_tracker
//
//  channel  dir   handshake              payload
//  req      in    req_tvalid/req_tready  tdata: text_byte; tlast: end_of_text
//  rsp      out   rsp_tvalid/rsp_tready  tdata: token_matched, first_offset, match_total
//  csr      in    csr_valid/csr_ready    csr_index, csr_data (64 bit)
//
//  one item per cycle sustained while no result waits; the window compare and token update
//  run combinationally from the item in the input register into the result register
//  a closing byte is taken into the input register and its result registered in the result register
//  a waiting result holds the input register; if empty it still takes one item
//  reset is synchronous and clears keyword, token state and match total
//  csr_ready is always high; configuration is expected while the block is idle
module token_substring_matcher (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,     // [7:0] text_byte
   input  logic         req_tlast,     // end_of_text

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,     // [0] token_matched, [8:1] first_offset,
                                       // [24:9] match_total, [31:25] zero

   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_data
);

   tsm_pkg::cfg_type    cfg;
   tsm_pkg::step_type   step;
   tsm_pkg::result_type result;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        advance;
   logic        delim;
   logic        key_hit;
   logic        rsp_valid;

   // the held item moves on whenever the result register is free or being drained
   assign advance    = in_valid_ff && (!rsp_valid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // space and newline end a token; end of text closes after its byte
   assign delim      = tsm_pkg::is_delim(in_byte_ff);
   assign step.shift = advance && !delim;
   assign step.close = advance && (delim || in_last_ff);

   tsm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tsm_window u_window (
      .clock     (clock),
      .shift     (step.shift),
      .text_byte (in_byte_ff),
      .cfg       (cfg),
      .key_hit   (key_hit)
   );

   tsm_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .key_hit    (key_hit),
      .key_length (cfg.key_length),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_valid),
      .result     (result)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {7'd0, result.match_total, result.first_offset,
                        result.token_matched};

endmodule

### sim/token_substring_matcher_test.sv
// self-checking testbench for the token substring matcher: streams text, checks token results
// depends on tsm_pkg and the token_substring_matcher rtl; needs no files or arguments
`timescale 1ns / 100ps

module token_substring_matcher_test;

   // no item moves on any channel for this long: the run is stuck
   localparam int STUCK_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } text_item_type;

   // receiver stall styles, picked anew at random as the run goes on
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_COIN,
      RX_PERIODIC,
      RX_LONG_STALLS
   } rx_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;

   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;     // [7:0] text_byte
   logic         req_tlast = 1'b0;   // end_of_text

   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;          // [0] token_matched, [8:1] first_offset,
                                     // [24:9] match_total, [31:25] zero

   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [63:0]  csr_data = '0;

   // text waiting to be sent, and token results still owed by the block
   text_item_type       text_items[$];
   tsm_pkg::result_type token_results[$];
   int                  queued_count = 0;
   int                  error_count = 0;

   // predictor copy of the keyword registers
   logic [63:0]   keyword_low = '0;
   logic [63:0]   keyword_high = '0;
   logic [4:0]    keyword_len = '0;
   logic          fold_on = 1'b0;

   // predictor copy of the open token
   logic [7:0]    window_bytes[tsm_pkg::MAX_KEY_LEN];
   logic [7:0]    token_len = '0;
   logic [7:0]    first_hit = '0;
   logic          hit_found = 1'b0;
   logic [15:0]   matching_total = '0;

   // sender burst state
   logic          send_now;
   int            burst_left = 1;
   int            gap_left = 0;

   // receiver stall state
   rx_mode_type   rx_mode = RX_ALWAYS;
   int            rx_hold = 0;
   int            rx_count = 0;
   logic          take_next;

   int            stuck_cycles = 0;

   logic [63:0]   key_lo, key_hi;

   token_substring_matcher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      foreach (window_bytes[k]) window_bytes[k] = '0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [7:0] folded(input logic [7:0] c);
      if (fold_on && c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   function automatic logic [7:0] keyword_byte(input int i);
      if (i < 8) begin
         return keyword_low[8*i +: 8];
      end
      return keyword_high[8*(i-8) +: 8];
   endfunction

   // does the keyword end at the newest byte of the token
   function automatic logic keyword_at_tail();
      int i;
      if (keyword_len == 0 || keyword_len > tsm_pkg::MAX_KEY_LEN) return 1'b0;
      if (token_len < keyword_len) return 1'b0;
      for (i = 0; i < keyword_len; i++) begin
         if (folded(keyword_byte(i)) != folded(window_bytes[keyword_len - 1 - i])) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // one accepted text byte: update the open token, owe a result when it closes
   task automatic scan_text_byte(input logic [7:0] b, input logic eot);
      logic                is_sep;
      logic                at_limit;
      tsm_pkg::result_type r;
      int                  i;
      is_sep = (b == tsm_pkg::CHAR_SPACE) || (b == tsm_pkg::CHAR_NEWLINE);
      if (!is_sep) begin
         at_limit = (token_len == tsm_pkg::OFFSET_MAX);
         for (i = tsm_pkg::MAX_KEY_LEN - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
         window_bytes[0] = b;
         if (!at_limit) token_len = token_len + 8'd1;
         // only the first occurrence counts; past 255 the offset sticks at the top
         if (!hit_found && keyword_at_tail()) begin
            hit_found = 1'b1;
            first_hit = at_limit ? tsm_pkg::OFFSET_MAX : token_len - 8'(keyword_len);
         end
      end
      if (is_sep || eot) begin
         // empty tokens (leading or repeated separators) give nothing
         if (token_len != 0) begin
            if (hit_found && matching_total != tsm_pkg::TOTAL_MAX) begin
               matching_total = matching_total + 16'd1;
            end
            r.token_matched = hit_found;
            r.first_offset  = hit_found ? first_hit : 8'd0;
            r.match_total   = matching_total;
            token_results.push_back(r);
         end
         foreach (window_bytes[k]) window_bytes[k] = '0;
         token_len = '0;
         first_hit = '0;
         hit_found = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic flag_mismatch(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   task automatic check_token_result(input logic [31:0] word);
      tsm_pkg::result_type seen, want;
      seen = tsm_pkg::result_type'(word[24:0]);
      if (token_results.size() == 0) begin
         flag_mismatch($sformatf("result with none owed: matched %0d offset %0d total %0d",
                                 seen.token_matched, seen.first_offset, seen.match_total));
      end else begin
         want = token_results.pop_front();
         if (seen.token_matched !== want.token_matched ||
             seen.first_offset  !== want.first_offset ||
             seen.match_total   !== want.match_total) begin
            flag_mismatch($sformatf({"token result: expected matched %0d offset %0d total %0d,",
                                     " got matched %0d offset %0d total %0d"},
                                    want.token_matched, want.first_offset, want.match_total,
                                    seen.token_matched, seen.first_offset, seen.match_total));
         end
      end
   endtask

   // ---------------------------------------------------------------- sender

   // bursts of random length with random gaps; a held item is never withdrawn
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            scan_text_byte(req_tdata, req_tlast);
            void'(text_items.pop_front());
         end
         send_now = 1'b0;
         if (req_tvalid && !req_tready) begin
            send_now = 1'b1;
         end else if (gap_left != 0) begin
            gap_left--;
         end else if (text_items.size() != 0) begin
            send_now = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               // a third of bursts run straight into the next one
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         req_tvalid <= send_now;
         if (send_now) begin
            req_tdata <= text_items[0].text_byte;
            req_tlast <= text_items[0].end_of_text;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_token_result(rsp_tdata);
         rx_count++;
         if (rx_count % 160 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
         if (rx_hold != 0) begin
            rx_hold--;
            take_next = 1'b0;
         end else begin
            case (rx_mode)
               RX_ALWAYS:   take_next = 1'b1;
               RX_COIN:     take_next = 1'($urandom_range(0, 1));
               RX_PERIODIC: take_next = (rx_count % 5) != 0;
               default: begin
                  take_next = 1'b1;
                  if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(4, 30);
               end
            endcase
         end
         rsp_tready <= take_next;
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus helpers

   task automatic push_text(input logic [7:0] b, input logic eot);
      text_items.push_back('{text_byte: b, end_of_text: eot});
      queued_count++;
   endtask

   task automatic push_word(input string s, input logic eot_on_last);
      int i;
      for (i = 0; i < s.len(); i++) push_text(s[i], eot_on_last && (i == s.len() - 1));
   endtask

   // config write; the predictor takes the new value once the block has it
   task automatic write_register(input tsm_pkg::csr_index_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         tsm_pkg::CSR_KEY_LOW:  keyword_low  = value;
         tsm_pkg::CSR_KEY_HIGH: keyword_high = value;
         tsm_pkg::CSR_KEY_LEN:  keyword_len  = value[4:0];
         tsm_pkg::CSR_FOLD:     fold_on      = value[0];
      endcase
   endtask

   task automatic set_keyword(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len, input logic fold);
      write_register(tsm_pkg::CSR_KEY_LOW, lo);
      write_register(tsm_pkg::CSR_KEY_HIGH, hi);
      write_register(tsm_pkg::CSR_KEY_LEN, 64'(len));
      write_register(tsm_pkg::CSR_FOLD, 64'(fold));
   endtask

   // wait for the sender to drain and every owed result, then let the pipe empty
   task automatic settle();
      while (text_items.size() != 0 || req_tvalid || token_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   function automatic logic [7:0] random_letter();
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
   endfunction

   // any byte that is not a separator
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == tsm_pkg::CHAR_SPACE || b == tsm_pkg::CHAR_NEWLINE) b = b ^ 8'h80;
      return b;
   endfunction

   task automatic fill_key(input logic letters_only, output logic [63:0] lo, output logic [63:0] hi);
      logic [127:0] all;
      int           i;
      for (i = 0; i < 16; i++) all[8*i +: 8] = letters_only ? random_letter() : plain_byte();
      lo = all[63:0];
      hi = all[127:64];
   endtask

   // letters flip case at random so folding is exercised both ways
   function automatic logic [7:0] vary_case(input logic [7:0] b);
      if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) && $urandom_range(0, 1)) begin
         return b ^ 8'h20;
      end
      return b;
   endfunction

   // keyword bytes to plant; a disabled key still gets its bytes sent
   function automatic int planted_len();
      return (keyword_len >= 1 && keyword_len <= tsm_pkg::MAX_KEY_LEN) ?
             int'(keyword_len) : tsm_pkg::MAX_KEY_LEN;
   endfunction

   function automatic logic [7:0] filler_byte();
      if ($urandom_range(0, 1)) return vary_case(keyword_byte($urandom_range(0, planted_len() - 1)));
      return random_letter();
   endfunction

   // mostly tokens built around the keyword or a near miss, some raw noise
   task automatic queue_random_text(input int budget);
      logic [7:0] word_bytes[$];
      int         stop_at, pick, n, i;
      logic       eot_here;
      stop_at = queued_count + budget;
      while (queued_count < stop_at) begin
         word_bytes.delete();
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            repeat ($urandom_range(0, 4)) word_bytes.push_back(filler_byte());
            // full keyword two times in three, otherwise a partial one
            n = ($urandom_range(0, 2) != 0) ? planted_len() : $urandom_range(0, planted_len());
            for (i = 0; i < n; i++) word_bytes.push_back(vary_case(keyword_byte(i)));
            repeat ($urandom_range(0, 3)) word_bytes.push_back(filler_byte());
         end else if (pick < 9) begin
            repeat ($urandom_range(1, 6)) word_bytes.push_back(8'($urandom_range(0, 255)));
         end
         eot_here = ($urandom_range(0, 15) == 0);
         foreach (word_bytes[k]) begin
            push_text(word_bytes[k], eot_here && (k == word_bytes.size() - 1) && pick < 9);
         end
         // close with separators unless end of text already closed it
         if (!(eot_here && pick < 9)) begin
            n = $urandom_range(1, 2);
            for (i = 0; i < n; i++) begin
               push_text($urandom_range(0, 1) ? tsm_pkg::CHAR_SPACE : tsm_pkg::CHAR_NEWLINE,
                         eot_here && (i == n - 1));
            end
         end
      end
   endtask

   task automatic run_phase(input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] len,
                            input logic fold, input int budget);
      set_keyword(lo, hi, len, fold);
      queue_random_text(budget);
      settle();
   endtask

   // filler token with the keyword "wxyz" placed after a run of lead bytes
   task automatic push_long_token(input int lead, input logic with_key);
      repeat (lead) push_text(8'h61, 1'b0);
      if (with_key) push_word("wxyz", 1'b0);
      push_text(tsm_pkg::CHAR_SPACE, 1'b0);
   endtask

   // ---------------------------------------------------------------- test sequence

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // after reset the key length is zero: a token closes without a match
      push_word("ab", 1'b0);
      push_text(tsm_pkg::CHAR_SPACE, 1'b0);
      settle();

      // keyword "aab" with folding
      set_keyword(64'h0000_0000_0062_6161, 64'h0, 5'd3, 1'b1);
      push_text(tsm_pkg::CHAR_SPACE, 1'b0);    // leading separator, no token
      push_word("xAaAB", 1'b0);                // overlapping start, found at 2 by folding
      push_text(tsm_pkg::CHAR_NEWLINE, 1'b0);
      push_text(tsm_pkg::CHAR_NEWLINE, 1'b0);  // repeated separator
      push_text(8'h00, 1'b0);                  // null and all-ones are plain token bytes
      push_text(8'hFF, 1'b0);
      push_text(tsm_pkg::CHAR_SPACE, 1'b0);
      push_word("Zaab", 1'b1);                 // end of text on a plain byte closes the token
      push_word("q", 1'b0);
      push_text(tsm_pkg::CHAR_SPACE, 1'b1);    // end of text on a separator
      push_text(tsm_pkg::CHAR_SPACE, 1'b1);    // end of text with nothing open
      settle();

      // key length above the maximum never matches
      write_register(tsm_pkg::CSR_KEY_LEN, 64'd17);
      push_word("aab ", 1'b0);
      settle();

      // random text under a range of keywords, extremes included
      fill_key(1'b1, key_lo, key_hi);
      run_phase(key_lo, key_hi, 5'd5, 1'b1, 30);
      fill_key(1'b1, key_lo, key_hi);
      run_phase(key_lo, key_hi, 5'd1, 1'b0, 25);
      fill_key(1'b1, key_lo, key_hi);
      run_phase(key_lo, key_hi, 5'd16, 1'b1, 30);
      fill_key(1'b0, key_lo, key_hi);
      run_phase(key_lo, key_hi, 5'd16, 1'b0, 30);
      run_phase(64'h0000_0000_FF00_FF00, 64'h0, 5'd4, 1'b1, 25);   // null / all-ones key bytes
      run_phase(64'h0000_0000_0061_6161, 64'h0, 5'd3, 1'b1, 30);   // "aaa": overlapping starts
      fill_key(1'b0, key_lo, key_hi);
      run_phase(key_lo, key_hi, 5'd0, 1'b1, 20);                   // disabled
      fill_key(1'b1, key_lo, key_hi);
      run_phase(key_lo, key_hi, 5'd31, 1'b0, 20);                  // length field at its top
      fill_key(1'b1, key_lo, key_hi);
      run_phase(key_lo, key_hi, 5'd17, 1'b1, 20);
      fill_key(1'b0, key_lo, key_hi);
      run_phase(key_lo, key_hi, 5'd9, 1'b0, 30);

      // long tokens: the offset climbs to its limit and then sticks
      set_keyword(64'h0000_0000_7A79_7877, 64'h0, 5'd4, 1'b0);
      push_long_token(251, 1'b1);
      push_long_token(252, 1'b1);
      settle();

      repeat (10) @(posedge clock);
      if (token_results.size() != 0) begin
         flag_mismatch($sformatf("%0d token results never arrived", token_results.size()));
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
